// ----- design/bba_pkg.sv -----
// Shared operation codes and widths for the block bitmap allocator.
`default_nettype none

package bba_pkg;

    localparam int INDEX_W = 10;

    typedef enum logic [1:0] {
        OP_TEST  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FIND  = 2'd3
    } op_t;

endpackage

`default_nettype wire

// ----- design/block_bitmap_allocator.sv -----
// Top level of the block bitmap allocator: sequencer, bitmap memory and result register.
// Test, set and clear: states S_READ, S_CHK, S_DONE (read, update, result).
// Find: S_READ, then S_SCAN over the bitmap words, one word per cycle through the shared
// word unit until a free bit or the last word is reached, then S_DONE.
// One request is in flight at a time; the next beat is taken the cycle after the result
// is loaded. After reset a clearing pass zeroes every word of the bitmap memory.
`default_nettype none

module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024,
    parameter int WORD_BITS  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic [INDEX_W-1:0] block_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    bit_used,
    output logic      [INDEX_W-1:0] free_index,
    output logic                    none_free
);

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_READ,
        S_CHK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic                 in_range_reg;
    logic [AW-1:0]        addr_reg;
    logic [BW-1:0]        bit_reg;
    logic [INDEX_W-1:0]   base_reg;
    logic                 pend_bit_reg;
    logic [INDEX_W-1:0]   pend_free_reg;
    logic                 pend_none_reg;
    logic                 out_valid_reg;
    logic                 bit_used_reg;
    logic [INDEX_W-1:0]   free_index_reg;
    logic                 none_free_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] pad_mask;
    logic                 wu_bit;
    logic [WORD_BITS-1:0] wu_word;
    logic                 wu_any_free;
    logic [BW-1:0]        wu_free_pos;
    logic                 in_accept;
    logic                 out_free;
    logic                 in_range;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_range   = int'(block_index) < NUM_BLOCKS;
    assign out_valid  = out_valid_reg;
    assign bit_used   = bit_used_reg;
    assign free_index = free_index_reg;
    assign none_free  = none_free_reg;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            pad_mask[i] = (addr_reg == LAST_ADDR) && (i >= LAST_BITS);
        end
    end

    always_comb
    begin
        if (state_reg == S_SCAN && addr_reg != LAST_ADDR)
        begin
            ram_raddr = addr_reg + AW'(1);
        end
        else
        begin
            ram_raddr = addr_reg;
        end
    end

    assign ram_we = (state_reg == S_CLR) ||
                    (state_reg == S_CHK && in_range_reg &&
                     (op_reg == OP_SET || op_reg == OP_CLEAR));
    assign ram_wdata = (state_reg == S_CLR) ? '0 : wu_word;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word_unit (
        .word_in  (ram_rdata),
        .bit_sel  (bit_reg),
        .op       (op_reg),
        .pad_mask (pad_mask),
        .bit_val  (wu_bit),
        .word_out (wu_word),
        .any_free (wu_any_free),
        .free_pos (wu_free_pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            op_reg         <= OP_TEST;
            in_range_reg   <= 1'b0;
            addr_reg       <= '0;
            bit_reg        <= '0;
            base_reg       <= '0;
            pend_bit_reg   <= 1'b0;
            pend_free_reg  <= '0;
            pend_none_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            bit_used_reg   <= 1'b0;
            free_index_reg <= '0;
            none_free_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    if (addr_reg == LAST_ADDR)
                    begin
                        addr_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg       <= op_t'(op);
                        in_range_reg <= in_range;
                        bit_reg      <= BW'(block_index % WORD_BITS);
                        base_reg     <= '0;
                        if (op_t'(op) == OP_FIND || !in_range)
                        begin
                            addr_reg <= '0;
                        end
                        else
                        begin
                            addr_reg <= AW'(block_index / WORD_BITS);
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= (op_reg == OP_FIND) ? S_SCAN : S_CHK;
                end
                S_CHK:
                begin
                    pend_bit_reg  <= (op_reg == OP_TEST) && in_range_reg && wu_bit;
                    pend_free_reg <= '0;
                    pend_none_reg <= 1'b0;
                    state_reg     <= S_DONE;
                end
                S_SCAN:
                begin
                    pend_bit_reg <= 1'b0;
                    if (wu_any_free)
                    begin
                        pend_free_reg <= base_reg + INDEX_W'(wu_free_pos);
                        pend_none_reg <= 1'b0;
                        state_reg     <= S_DONE;
                    end
                    else if (addr_reg == LAST_ADDR)
                    begin
                        pend_free_reg <= '0;
                        pend_none_reg <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + AW'(1);
                        base_reg <= base_reg + INDEX_W'(WORD_BITS);
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        bit_used_reg   <= pend_bit_reg;
                        free_index_reg <= pend_free_reg;
                        none_free_reg  <= pend_none_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_full_has_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none_free |-> free_index == '0)
        else $error("none_free result carries a nonzero free_index");

    a_test_not_find: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(bit_used && none_free))
        else $error("bit_used and none_free both set in one result");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input taken again while a request is in progress");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !out_valid_reg)
        else $error("result presented during the clearing pass");

endmodule

`default_nettype wire

// ----- design/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/bba_word_unit.sv -----
// Shared word unit: bit test, set/clear update and first-free search on one bitmap word.
`default_nettype none

module bba_word_unit
    import bba_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic [WORD_BITS-1:0]         word_in,
    input  wire logic [$clog2(WORD_BITS)-1:0] bit_sel,
    input  wire op_t                          op,
    input  wire logic [WORD_BITS-1:0]         pad_mask,
    output logic                              bit_val,
    output logic      [WORD_BITS-1:0]         word_out,
    output logic                              any_free,
    output logic      [$clog2(WORD_BITS)-1:0] free_pos
);

    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] occupied;

    assign bit_val  = word_in[bit_sel];
    assign occupied = word_in | pad_mask;

    always_comb
    begin
        word_out = word_in;
        case (op)
            OP_SET:   word_out[bit_sel] = 1'b1;
            OP_CLEAR: word_out[bit_sel] = 1'b0;
            default:  word_out = word_in;
        endcase
    end

    always_comb
    begin
        any_free = 1'b0;
        free_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!occupied[i])
            begin
                any_free = 1'b1;
                free_pos = BW'(i);
            end
        end
    end

endmodule

`default_nettype wire
